// ===== rtl/onewire_master_engine_core_defines.svh =====
// assertion macros used by the checker file of the one-wire master engine
// no dependencies; every macro expects clk and rst_n in scope
`ifndef ONEWIRE_MASTER_ENGINE_CORE_DEFINES_SVH
`define ONEWIRE_MASTER_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OMWE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define OMWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/omwe_pkg.sv =====
// shared types, codes and constants of the one-wire master engine
// no dependencies
package omwe_pkg;

  localparam int unsigned TickW   = 10;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned CfgIdxW = 4;

  // fixed recovery times after a write slot
  localparam logic [TickW-1:0] WriteOneRecoverUs  = 10'd58;
  localparam logic [TickW-1:0] WriteZeroRecoverUs = 10'd2;

  // register reset values
  localparam logic [TickW-1:0] ResetLowRst      = 10'd750;
  localparam logic [TickW-1:0] ResetReleaseRst  = 10'd15;
  localparam logic [TickW-1:0] PresenceWaitRst  = 10'd100;
  localparam logic [TickW-1:0] PresenceMaxRst   = 10'd240;
  localparam logic [TickW-1:0] WriteOneLowRst   = 10'd8;
  localparam logic [TickW-1:0] WriteZeroLowRst  = 10'd70;
  localparam logic [TickW-1:0] ReadLowRst       = 10'd10;
  localparam logic [TickW-1:0] ReadRecoverRst   = 10'd45;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RESET_LOW     = 4'd0,
    CFG_RESET_RELEASE = 4'd1,
    CFG_PRESENCE_WAIT = 4'd2,
    CFG_PRESENCE_MAX  = 4'd3,
    CFG_WRITE_ONE_LOW = 4'd4,
    CFG_WRITE_ZERO_LOW = 4'd5,
    CFG_READ_LOW      = 4'd6,
    CFG_READ_RECOVER  = 4'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_RESET = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REL   = 4'd2,
    PH_PRES_WAIT = 4'd3,
    PH_PRES_LOW  = 4'd4,
    PH_WR_LOW    = 4'd5,
    PH_WR_REC    = 4'd6,
    PH_RD_LOW    = 4'd7,
    PH_RD_REC    = 4'd8
  } phase_t;

  typedef struct packed {
    logic [TickW-1:0] reset_low_us;
    logic [TickW-1:0] reset_release_us;
    logic [TickW-1:0] presence_wait_us;
    logic [TickW-1:0] presence_max_us;
    logic [TickW-1:0] write_one_low_us;
    logic [TickW-1:0] write_zero_low_us;
    logic [TickW-1:0] read_low_us;
    logic [TickW-1:0] read_recover_us;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [TickW-1:0]   tick_count;
    logic [ByteW-1:0]   shift_byte;
    logic [BitIdxW-1:0] bit_index;
    logic               fail_flag;
    logic [ByteW-1:0]   read_byte;
  } eng_state_t;

  typedef struct packed {
    req_t             req_type;
    logic [ByteW-1:0] write_data;
    logic             bus_level;
  } in_beat_t;

  typedef struct packed {
    logic             drive_low;
    logic             busy_res;
    logic             done_res;
    logic             presence_fail;
    logic [ByteW-1:0] read_data;
    logic             rejected;
  } out_beat_t;

endpackage

// ===== rtl/omwe_cfg.sv =====
// timing register file of the one-wire master engine
// depends on omwe_pkg
module omwe_cfg import omwe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [TickW-1:0]   wr_data,
  output cfg_t               cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_RESET_LOW:      cfg_nxt.reset_low_us      = wr_data;
        CFG_RESET_RELEASE:  cfg_nxt.reset_release_us  = wr_data;
        CFG_PRESENCE_WAIT:  cfg_nxt.presence_wait_us  = wr_data;
        CFG_PRESENCE_MAX:   cfg_nxt.presence_max_us   = wr_data;
        CFG_WRITE_ONE_LOW:  cfg_nxt.write_one_low_us  = wr_data;
        CFG_WRITE_ZERO_LOW: cfg_nxt.write_zero_low_us = wr_data;
        CFG_READ_LOW:       cfg_nxt.read_low_us       = wr_data;
        CFG_READ_RECOVER:   cfg_nxt.read_recover_us   = wr_data;
        default: ;  // out-of-range index is dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_us      <= ResetLowRst;
      cfg_r.reset_release_us  <= ResetReleaseRst;
      cfg_r.presence_wait_us  <= PresenceWaitRst;
      cfg_r.presence_max_us   <= PresenceMaxRst;
      cfg_r.write_one_low_us  <= WriteOneLowRst;
      cfg_r.write_zero_low_us <= WriteZeroLowRst;
      cfg_r.read_low_us       <= ReadLowRst;
      cfg_r.read_recover_us   <= ReadRecoverRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/omwe_step.sv =====
// one-beat next-state and result logic of the one-wire master engine
// depends on omwe_pkg
module omwe_step import omwe_pkg::*; (
  input  eng_state_t cur,
  input  cfg_t       cfg,
  input  in_beat_t   beat,
  output eng_state_t nxt,
  output out_beat_t  res
);

  logic [TickW-1:0] tc_inc;
  logic             done;
  logic             rej;

  assign tc_inc = cur.tick_count + 10'd1;

  // next state
  always_comb begin
    logic [TickW-1:0] lim;
    logic [ByteW-1:0] sb;
    nxt  = cur;
    done = 1'b0;
    rej  = 1'b0;
    lim  = '0;
    sb   = cur.shift_byte;
    if (beat.req_type != REQ_TICK) begin
      if (cur.phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        nxt.bit_index  = '0;
        nxt.tick_count = '0;
        case (beat.req_type)
          REQ_RESET: nxt.phase = PH_RST_LOW;
          REQ_WRITE: begin
            nxt.phase      = PH_WR_LOW;
            nxt.shift_byte = beat.write_data;
          end
          default: begin
            nxt.phase      = PH_RD_LOW;
            nxt.shift_byte = '0;
          end
        endcase
      end
    end else begin
      nxt.tick_count = tc_inc;
      unique case (cur.phase)
        PH_RST_LOW: begin
          if (tc_inc >= cfg.reset_low_us) begin
            nxt.phase = PH_RST_REL; nxt.tick_count = '0;
          end
        end
        PH_RST_REL: begin
          if (tc_inc >= cfg.reset_release_us) begin
            nxt.phase = PH_PRES_WAIT; nxt.tick_count = '0;
          end
        end
        PH_PRES_WAIT: begin
          if (beat.bus_level) begin
            if (tc_inc >= cfg.presence_wait_us) begin
              nxt.fail_flag = 1'b1; done = 1'b1;
              nxt.phase = PH_IDLE; nxt.tick_count = '0;
            end
          end else begin
            // low sample is the first tick of the presence pulse
            nxt.phase      = PH_PRES_LOW;
            nxt.tick_count = 10'd1;
            if (10'd1 >= cfg.presence_max_us) begin
              nxt.fail_flag = 1'b1; done = 1'b1;
              nxt.phase = PH_IDLE; nxt.tick_count = '0;
            end
          end
        end
        PH_PRES_LOW: begin
          if (beat.bus_level) begin
            nxt.fail_flag = 1'b0; done = 1'b1;
            nxt.phase = PH_IDLE; nxt.tick_count = cur.tick_count;
            nxt.tick_count = '0;
          end else if (tc_inc >= cfg.presence_max_us) begin
            nxt.fail_flag = 1'b1; done = 1'b1;
            nxt.phase = PH_IDLE; nxt.tick_count = '0;
          end
        end
        PH_WR_LOW: begin
          lim = cur.shift_byte[0] ? cfg.write_one_low_us : cfg.write_zero_low_us;
          if (tc_inc >= lim) begin
            nxt.phase = PH_WR_REC; nxt.tick_count = '0;
          end
        end
        PH_WR_REC: begin
          lim = cur.shift_byte[0] ? WriteOneRecoverUs : WriteZeroRecoverUs;
          if (tc_inc >= lim) begin
            nxt.shift_byte = {1'b0, cur.shift_byte[ByteW-1:1]};
            nxt.tick_count = '0;
            if (cur.bit_index == 3'd7) begin
              nxt.phase = PH_IDLE; nxt.bit_index = '0; done = 1'b1;
            end else begin
              nxt.phase = PH_WR_LOW; nxt.bit_index = cur.bit_index + 3'd1;
            end
          end
        end
        PH_RD_LOW: begin
          if (tc_inc >= cfg.read_low_us) begin
            nxt.phase = PH_RD_REC; nxt.tick_count = '0;
          end
        end
        PH_RD_REC: begin
          // first tick after release carries the bit
          if (cur.tick_count == '0) begin
            sb[cur.bit_index] = cur.shift_byte[cur.bit_index] | beat.bus_level;
          end
          nxt.shift_byte = sb;
          if (tc_inc >= cfg.read_recover_us) begin
            nxt.tick_count = '0;
            if (cur.bit_index == 3'd7) begin
              nxt.phase = PH_IDLE; nxt.bit_index = '0;
              nxt.read_byte = sb; done = 1'b1;
            end else begin
              nxt.phase = PH_RD_LOW; nxt.bit_index = cur.bit_index + 3'd1;
            end
          end
        end
        default: begin
          nxt.phase = PH_IDLE; nxt.tick_count = '0;
        end
      endcase
    end
  end

  // outputs from the updated state
  always_comb begin
    res.drive_low     = (nxt.phase == PH_RST_LOW) || (nxt.phase == PH_WR_LOW) ||
                        (nxt.phase == PH_RD_LOW);
    res.busy_res      = (nxt.phase != PH_IDLE);
    res.done_res      = done;
    res.presence_fail = nxt.fail_flag;
    res.read_data     = nxt.read_byte;
    res.rejected      = rej;
  end

endmodule

// ===== rtl/onewire_master_engine_core.sv =====
// top level of the one-wire master timing engine: input stage, step logic, result stage
// depends on omwe_pkg, omwe_cfg, omwe_step
//
//  port group  | beat carries                                   | handshake
//  ------------+------------------------------------------------+-------------------
//  in_         | req_type, write_data, bus_level                | in_valid/in_ready
//  out_        | drive_low, busy_res, done_res, presence_fail,  | out_valid/out_ready
//              | read_data, rejected                            |
//  cfg_        | cfg_index (4 bits), cfg_data (10 bits)         | cfg_valid/cfg_ready
//
//  one beat a cycle sustained while out_ready stays high; a taken beat is held in the input register,
//  then passes through the step logic into the result register
//  the engine state advances when a beat moves from the input register to the result register
//  a stalled out_ready holds the result and, while the input register is full, drops in_ready in the same cycle
//  rst_n is synchronous, active low; it clears valids and engine state and loads default timings
//  cfg_ready is always high; writes land in the next cycle
module onewire_master_engine_core import omwe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [ByteW-1:0]   in_write_data,
  input  logic               in_bus_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_drive_low,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic               out_presence_fail,
  output logic [ByteW-1:0]   out_read_data,
  output logic               out_rejected,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TickW-1:0]   cfg_data
);

  cfg_t       cfg;
  in_beat_t   in_beat_r, in_beat_nxt;
  logic       in_valid_r, in_valid_nxt;
  eng_state_t state_r, state_nxt, step_state;
  out_beat_t  out_beat_r, out_beat_nxt, step_res;
  logic       out_valid_r, out_valid_nxt;
  logic       out_adv;
  logic       step_fire;

  assign cfg_ready = 1'b1;

  omwe_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // result register empties or is being taken
  assign out_adv   = !out_valid_r || out_ready;
  assign step_fire = in_valid_r && out_adv;
  assign in_ready  = !in_valid_r || out_adv;

  // input register
  always_comb begin
    in_valid_nxt = in_valid_r;
    in_beat_nxt  = in_beat_r;
    if (in_ready) begin
      in_valid_nxt = in_valid;
      in_beat_nxt.req_type   = req_t'(in_req_type);
      in_beat_nxt.write_data = in_write_data;
      in_beat_nxt.bus_level  = in_bus_level;
    end
  end

  omwe_step u_step (
    .cur  (state_r),
    .cfg  (cfg),
    .beat (in_beat_r),
    .nxt  (step_state),
    .res  (step_res)
  );

  // engine state and result register
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    if (out_adv) begin
      out_valid_nxt = in_valid_r;
    end
    if (step_fire) begin
      state_nxt    = step_state;
      out_beat_nxt = step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      state_r.phase       <= PH_IDLE;
      state_r.tick_count  <= '0;
      state_r.shift_byte  <= '0;
      state_r.bit_index   <= '0;
      state_r.fail_flag   <= 1'b0;
      state_r.read_byte   <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    in_beat_r  <= in_beat_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_drive_low     = out_beat_r.drive_low;
  assign out_busy_res      = out_beat_r.busy_res;
  assign out_done_res      = out_beat_r.done_res;
  assign out_presence_fail = out_beat_r.presence_fail;
  assign out_read_data     = out_beat_r.read_data;
  assign out_rejected      = out_beat_r.rejected;

endmodule

// ===== rtl/omwe_checker.sv =====
// port-level checker of the one-wire master engine, bound to the top level
// depends on omwe_pkg and onewire_master_engine_core_defines.svh
`include "onewire_master_engine_core_defines.svh"

module omwe_checker import omwe_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_drive_low,
  input logic             out_busy_res,
  input logic             out_done_res,
  input logic             out_presence_fail,
  input logic [ByteW-1:0] out_read_data,
  input logic             out_rejected
);

  `OMWE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_read_data) && $stable(out_busy_res) &&
    $stable(out_done_res) && $stable(out_presence_fail) && $stable(out_rejected),
    "stalled result beat changed")
  `OMWE_ASSERT_NOW(a_done_idle, out_valid && out_done_res, !out_busy_res && !out_drive_low, "finished operation still busy")
  `OMWE_ASSERT_NOW(a_rej_busy, out_valid && out_rejected, out_busy_res && !out_done_res, "rejected command while idle")
  `OMWE_ASSERT_NOW(a_drive_busy, out_valid && out_drive_low, out_busy_res, "bus driven low while idle")

endmodule

bind onewire_master_engine_core omwe_checker u_omwe_checker (.*);
